### rtl/abgt_pkg.sv
// ---------------------------------------------------------------------------
// abgt_pkg
// Widths, types and fixed-point helpers for the two-axis alpha-beta-gamma
// tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package abgt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W  = 32;
    localparam int DT_W   = 24;
    localparam int GAIN_W = 18;
    localparam int E_W    = POS_W + 1;

    // multiplier: magnitude of a 32/33-bit value times dt or a gain
    localparam int MUL_A_W = POS_W;
    localparam int MUL_B_W = DT_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int WIDE_W = 64;

    // divider numerator: |e|*gain + dt/2, or remainder<<FRAC_BITS + dt/2
    localparam int DIV_GAIN_W = POS_W + GAIN_W + 2;
    localparam int DIV_REM_W  = DT_W + FRAC_BITS + 1;
    localparam int DIV_W      = (DIV_GAIN_W > DIV_REM_W) ? DIV_GAIN_W : DIV_REM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // acceleration term caps at 2^33
    localparam int QH_SH = 33 - FRAC_BITS;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd2;

    localparam logic [GAIN_W-1:0] ALPHA_RST = 18'd65536;
    localparam logic [GAIN_W-1:0] BETA_RST  = 18'd26214;
    localparam logic [GAIN_W-1:0] GAMMA_RST = 18'd6554;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    localparam wide_t SAT_HI  = wide_t'(64'sd2147483647);
    localparam wide_t SAT_LO  = wide_t'(-64'sd2147483648);
    localparam logic [WIDE_W-1:0] MAG_CAP = 64'd1 << 33;

    typedef struct packed {
        logic [GAIN_W-1:0] alpha;
        logic [GAIN_W-1:0] beta;
        logic [GAIN_W-1:0] gamma;
    } gains_t;

    typedef struct packed {
        logic            start;
        pos_t            obs;
        logic [DT_W-1:0] dt;
    } lane_cmd_t;

    typedef struct packed {
        logic done;
        pos_t pos;
        pos_t vel;
        pos_t acc;
    } lane_stat_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DT_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DT_W-1:0]  rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_MUL_VD,
        L_MUL_ADD,
        L_PRED,
        L_ERR,
        L_POS,
        L_BDIV_LD,
        L_BDIV,
        L_GDIV_LD,
        L_GDIV,
        L_HDIV_LD,
        L_HDIV,
        L_RDIV_LD,
        L_RDIV
    } lane_state_t;

    function automatic logic [MUL_A_W-1:0] mag32(input pos_t x);
        return x[POS_W-1] ? MUL_A_W'(-x) : MUL_A_W'(x);
    endfunction

    function automatic logic [MUL_A_W-1:0] mag_e(input logic signed [E_W-1:0] x);
        return x[E_W-1] ? MUL_A_W'(-x) : MUL_A_W'(x);
    endfunction

    // round half away from zero on a magnitude
    function automatic logic [PROD_W-1:0] rnd_shift(input logic [PROD_W-1:0] m,
                                                   input int sh);
        logic [PROD_W:0] s;
        s = {1'b0, m} + ((PROD_W+1)'(1) << (sh - 1));
        return PROD_W'(s >> sh);
    endfunction

    function automatic wide_t sgn_apply(input logic neg, input logic [WIDE_W-1:0] m);
        return neg ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic pos_t sat32(input wide_t x);
        if (x > SAT_HI)
            return pos_t'(SAT_HI);
        else if (x < SAT_LO)
            return pos_t'(SAT_LO);
        else
            return pos_t'(x);
    endfunction

endpackage

`default_nettype wire

### rtl/abgt_if.sv
// ---------------------------------------------------------------------------
// abgt_if
// Valid/ready channels of the tracker: observations, estimates, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface abgt_obs_if
    import abgt_pkg::*;
();
    logic            valid;
    logic            ready;
    pos_t            obs_x;
    pos_t            obs_y;
    logic [DT_W-1:0] dt_sec;

    modport source (output valid, output obs_x, output obs_y, output dt_sec, input ready);
    modport sink   (input valid, input obs_x, input obs_y, input dt_sec, output ready);
endinterface

interface abgt_est_if
    import abgt_pkg::*;
();
    logic valid;
    logic ready;
    pos_t out_pos_x;
    pos_t out_pos_y;
    pos_t out_vel_x;
    pos_t out_vel_y;
    pos_t out_acc_x;
    pos_t out_acc_y;
    logic zero_dt_error;

    modport source (output valid, output out_pos_x, output out_pos_y, output out_vel_x,
                    output out_vel_y, output out_acc_x, output out_acc_y,
                    output zero_dt_error, input ready);
    modport sink   (input valid, input out_pos_x, input out_pos_y, input out_vel_x,
                    input out_vel_y, input out_acc_x, input out_acc_y,
                    input zero_dt_error, output ready);
endinterface

interface abgt_cfg_if
    import abgt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/abgt_div.sv
// ---------------------------------------------------------------------------
// abgt_div
// Restoring divider, one quotient bit per cycle, DIV_W-bit numerator by
// DT_W-bit divisor. Quotient and remainder hold until the next start.
// ---------------------------------------------------------------------------
`default_nettype none

module abgt_div
    import abgt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DT_W-1:0]      rem_reg, rem_next;
    logic [DT_W-1:0]      den_reg, den_next;

    logic [DT_W:0] trial;
    logic          ge;

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            cnt_next = DIV_CNT_W'(DIV_W);
            num_next = req.num;
            rem_next = '0;
            den_next = req.den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
            num_next  = {num_reg[DIV_W-2:0], ge};
            rem_next  = ge ? DT_W'(trial - {1'b0, den_reg}) : DT_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/abgt_lane.sv
// ---------------------------------------------------------------------------
// abgt_lane
// One tracking axis: position, velocity and acceleration state, a shared
// multiplier with registered product and a sequencer over its own divider.
// ---------------------------------------------------------------------------
`default_nettype none

module abgt_lane
    import abgt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lane_cmd_t cmd,
    input  wire gains_t    gains,
    output lane_stat_t     stat
);

    lane_state_t state_reg, state_next;

    pos_t p_reg, p_next;
    pos_t v_reg, v_next;
    pos_t a_reg, a_next;

    pos_t                   z_reg, z_next;
    logic [DT_W-1:0]        d_reg, d_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   mneg_reg, mneg_next;
    pos_t                   ad_reg, ad_next;
    wide_t                  pt_reg, pt_next;
    pos_t                   pp_reg, pp_next;
    pos_t                   pv_reg, pv_next;
    logic signed [E_W-1:0]  e_reg, e_next;
    logic signed [E_W-1:0]  e_diff;
    logic [DIV_W-1:0]       qh_reg, qh_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_neg;
    logic               mul_en;
    logic               lane_done;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [DIV_W-1:0]  half_d;
    logic [WIDE_W-1:0] t_mag;
    logic              t_cap;

    abgt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign half_d = DIV_W'(d_reg >> 1);
    assign e_diff = E_W'(z_reg) - E_W'(pp_reg);

    // acceleration term from qh = u div d and the last rounded quotient
    assign t_cap = ((qh_reg >> QH_SH) != '0);
    always_comb
    begin
        t_mag = (WIDE_W'(qh_reg) << FRAC_BITS) + WIDE_W'(div_rsp.quo);
        if (t_cap || (t_mag > MAG_CAP))
            t_mag = MAG_CAP;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:    if (cmd.start) state_next = L_MUL_VD;
            L_MUL_VD:  state_next = L_MUL_ADD;
            L_MUL_ADD: state_next = L_PRED;
            L_PRED:    state_next = L_ERR;
            L_ERR:     state_next = L_POS;
            L_POS:     state_next = L_BDIV_LD;
            L_BDIV_LD: state_next = L_BDIV;
            L_BDIV:    if (div_rsp.done) state_next = L_GDIV_LD;
            L_GDIV_LD: state_next = L_GDIV;
            L_GDIV:    if (div_rsp.done) state_next = L_HDIV_LD;
            L_HDIV_LD: state_next = L_HDIV;
            L_HDIV:    if (div_rsp.done) state_next = L_RDIV_LD;
            L_RDIV_LD: state_next = L_RDIV;
            L_RDIV:    if (div_rsp.done) state_next = L_IDLE;
            default:   state_next = L_IDLE;
        endcase
    end

    // multiplier operands, divider requests, completion
    always_comb
    begin
        mul_a         = '0;
        mul_b         = '0;
        mul_neg       = 1'b0;
        mul_en        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = d_reg;
        lane_done     = 1'b0;
        case (state_reg)
            L_IDLE:
            begin
                mul_en  = cmd.start;
                mul_a   = mag32(a_reg);
                mul_b   = cmd.dt;
                mul_neg = a_reg[POS_W-1];
            end
            L_MUL_VD:
            begin
                mul_en  = 1'b1;
                mul_a   = mag32(v_reg);
                mul_b   = d_reg;
                mul_neg = v_reg[POS_W-1];
            end
            L_MUL_ADD:
            begin
                mul_en  = 1'b1;
                mul_a   = mag32(ad_reg);
                mul_b   = d_reg;
                mul_neg = ad_reg[POS_W-1];
            end
            L_ERR:
            begin
                mul_en  = 1'b1;
                mul_a   = mag_e(e_diff);
                mul_b   = MUL_B_W'(gains.alpha);
                mul_neg = e_diff[E_W-1];
            end
            L_POS:
            begin
                mul_en  = 1'b1;
                mul_a   = mag_e(e_reg);
                mul_b   = MUL_B_W'(gains.beta);
                mul_neg = e_reg[E_W-1];
            end
            L_BDIV_LD:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'(prod_reg) + half_d;
                mul_en        = 1'b1;
                mul_a         = mag_e(e_reg);
                mul_b         = MUL_B_W'(gains.gamma);
                mul_neg       = e_reg[E_W-1];
            end
            L_GDIV_LD:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'(prod_reg) + half_d;
            end
            L_HDIV_LD:
            begin
                div_req.start = 1'b1;
                div_req.num   = div_rsp.quo;
            end
            L_RDIV_LD:
            begin
                div_req.start = 1'b1;
                div_req.num   = (DIV_W'(div_rsp.rem) << FRAC_BITS) + half_d;
            end
            L_RDIV:
            begin
                lane_done = div_rsp.done;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        p_next    = p_reg;
        v_next    = v_reg;
        a_next    = a_reg;
        z_next    = z_reg;
        d_next    = d_reg;
        prod_next = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_reg;
        mneg_next = mul_en ? mul_neg : mneg_reg;
        ad_next   = ad_reg;
        pt_next   = pt_reg;
        pp_next   = pp_reg;
        pv_next   = pv_reg;
        e_next    = e_reg;
        qh_next   = qh_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (cmd.start)
                begin
                    z_next = cmd.obs;
                    d_next = cmd.dt;
                end
            end
            L_MUL_VD:
            begin
                ad_next = sat32(sgn_apply(mneg_reg,
                                WIDE_W'(rnd_shift(prod_reg, FRAC_BITS))));
            end
            L_MUL_ADD:
            begin
                pt_next = wide_t'(p_reg) + sgn_apply(mneg_reg,
                                WIDE_W'(rnd_shift(prod_reg, FRAC_BITS)));
            end
            L_PRED:
            begin
                pp_next = sat32(pt_reg + sgn_apply(mneg_reg,
                                WIDE_W'(rnd_shift(prod_reg, FRAC_BITS + 1))));
                pv_next = sat32(wide_t'(v_reg) + wide_t'(ad_reg));
            end
            L_ERR:
            begin
                e_next = e_diff;
            end
            L_POS:
            begin
                p_next = sat32(wide_t'(pp_reg) + sgn_apply(e_reg[E_W-1],
                                WIDE_W'(rnd_shift(prod_reg, FRAC_BITS))));
            end
            L_BDIV:
            begin
                if (div_rsp.done)
                    v_next = sat32(wide_t'(pv_reg) + sgn_apply(e_reg[E_W-1],
                                   WIDE_W'(div_rsp.quo)));
            end
            L_HDIV:
            begin
                if (div_rsp.done)
                    qh_next = div_rsp.quo;
            end
            L_RDIV:
            begin
                if (div_rsp.done)
                    a_next = sat32(wide_t'(a_reg) + sgn_apply(e_reg[E_W-1], t_mag));
            end
            default:
            begin
                qh_next = qh_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            p_reg     <= '0;
            v_reg     <= '0;
            a_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            v_reg     <= v_next;
            a_reg     <= a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        mneg_reg <= mneg_next;
        ad_reg   <= ad_next;
        pt_reg   <= pt_next;
        pp_reg   <= pp_next;
        pv_reg   <= pv_next;
        e_reg    <= e_next;
        qh_reg   <= qh_next;
    end

    assign stat.done = lane_done;
    assign stat.pos  = p_reg;
    assign stat.vel  = v_reg;
    assign stat.acc  = a_reg;

endmodule

`default_nettype wire

### rtl/abgt_merge.sv
// ---------------------------------------------------------------------------
// abgt_merge
// Joins the completion of both axis lanes, or a zero-dt transaction, into
// one estimate and holds it in the output register until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module abgt_merge
    import abgt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       zero_dt,
    input  wire lane_stat_t stat_x,
    input  wire lane_stat_t stat_y,
    output logic            idle,
    abgt_est_if.source      est_ch
);

    logic busy_reg, busy_next;
    logic xdone_reg, xdone_next;
    logic ydone_reg, ydone_next;
    logic pend_reg, pend_next;
    logic perr_reg, perr_next;
    logic ovld_reg, ovld_next;

    pos_t pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg, acc_x_reg, acc_y_reg;
    logic err_reg;

    logic xdone, ydone, both_done, load;

    assign xdone     = xdone_reg | stat_x.done;
    assign ydone     = ydone_reg | stat_y.done;
    assign both_done = busy_reg & xdone & ydone;
    assign load      = pend_reg & (~ovld_reg | est_ch.ready);
    assign idle      = ~busy_reg & ~pend_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        xdone_next = xdone_reg;
        ydone_next = ydone_reg;
        pend_next  = pend_reg;
        perr_next  = perr_reg;
        ovld_next  = ovld_reg;

        if (est_ch.ready)
            ovld_next = 1'b0;
        if (load)
        begin
            ovld_next = 1'b1;
            pend_next = 1'b0;
        end

        if (start)
        begin
            busy_next  = 1'b1;
            xdone_next = 1'b0;
            ydone_next = 1'b0;
        end
        else if (both_done)
        begin
            busy_next = 1'b0;
            pend_next = 1'b1;
            perr_next = 1'b0;
        end
        else if (busy_reg)
        begin
            xdone_next = xdone;
            ydone_next = ydone;
        end

        if (zero_dt)
        begin
            pend_next = 1'b1;
            perr_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            xdone_reg <= 1'b0;
            ydone_reg <= 1'b0;
            pend_reg  <= 1'b0;
            perr_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            xdone_reg <= xdone_next;
            ydone_reg <= ydone_next;
            pend_reg  <= pend_next;
            perr_reg  <= perr_next;
            ovld_reg  <= ovld_next;
        end
    end

    // lane state is stable while a result is pending
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_x_reg <= stat_x.pos;
            pos_y_reg <= stat_y.pos;
            vel_x_reg <= stat_x.vel;
            vel_y_reg <= stat_y.vel;
            acc_x_reg <= stat_x.acc;
            acc_y_reg <= stat_y.acc;
            err_reg   <= perr_reg;
        end
    end

    assign est_ch.valid         = ovld_reg;
    assign est_ch.out_pos_x     = pos_x_reg;
    assign est_ch.out_pos_y     = pos_y_reg;
    assign est_ch.out_vel_x     = vel_x_reg;
    assign est_ch.out_vel_y     = vel_y_reg;
    assign est_ch.out_acc_x     = acc_x_reg;
    assign est_ch.out_acc_y     = acc_y_reg;
    assign est_ch.zero_dt_error = err_reg;

endmodule

`default_nettype wire

### rtl/alpha_beta_gamma_tracker_2d.sv
// ---------------------------------------------------------------------------
// alpha_beta_gamma_tracker_2d
// Two-axis alpha-beta-gamma tracker with constant-acceleration prediction.
//
//   channel  dir   transaction
//   obs_ch   in    observed x, y (Q16.16) and dt (Q8.16 s)
//   est_ch   out   position, velocity, acceleration per axis, zero-dt flag
//   cfg_ch   in    gain register write (alpha, beta, gamma), always ready
//
// Each observation runs four divides in series on the per-lane divider,
// one quotient bit a cycle. Both axes run side by side in their own lanes.
// A zero-dt transaction returns the current estimate without running the lanes.
// obs_ch.ready drops while a lane runs or a result waits to enter the output
// register; a stalled est_ch holds at most one result there.
// Reset clears the estimate and loads the default gains.
// ---------------------------------------------------------------------------
`default_nettype none

module alpha_beta_gamma_tracker_2d
    import abgt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    abgt_obs_if.sink  obs_ch,
    abgt_est_if.source est_ch,
    abgt_cfg_if.sink  cfg_ch
);

    gains_t gains_reg, gains_next;

    lane_cmd_t  cmd_x, cmd_y;
    lane_stat_t stat_x, stat_y;

    logic idle, accept, start, zero_dt;

    assign obs_ch.ready = idle;
    assign cfg_ch.ready = 1'b1;

    assign accept  = obs_ch.valid & obs_ch.ready;
    assign start   = accept & (obs_ch.dt_sec != '0);
    assign zero_dt = accept & (obs_ch.dt_sec == '0);

    assign cmd_x.start = start;
    assign cmd_x.obs   = obs_ch.obs_x;
    assign cmd_x.dt    = obs_ch.dt_sec;
    assign cmd_y.start = start;
    assign cmd_y.obs   = obs_ch.obs_y;
    assign cmd_y.dt    = obs_ch.dt_sec;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_ALPHA: gains_next.alpha = cfg_ch.data;
                CFG_BETA:  gains_next.beta  = cfg_ch.data;
                CFG_GAMMA: gains_next.gamma = cfg_ch.data;
                default:   gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.alpha <= ALPHA_RST;
            gains_reg.beta  <= BETA_RST;
            gains_reg.gamma <= GAMMA_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    abgt_lane u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_x),
        .gains (gains_reg),
        .stat  (stat_x)
    );

    abgt_lane u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_y),
        .gains (gains_reg),
        .stat  (stat_y)
    );

    abgt_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .zero_dt (zero_dt),
        .stat_x  (stat_x),
        .stat_y  (stat_y),
        .idle    (idle),
        .est_ch  (est_ch)
    );

endmodule

`default_nettype wire
